// ===== rtl/core/zlh_pkg.sv =====
package zlh_pkg;

   localparam int ENC_HEADER_BYTES = 12;
   localparam int INITIAL_BYTES    = 32;

   localparam logic [31:0] SIG_VALUE     = 32'h04034B50;
   localparam logic [31:0] VERSION_VALUE = 32'h00000014;
   localparam logic [31:0] ZIP64_SIZE    = 32'hFFFFFFFF;
   localparam int          FLAG_ENCRYPTED_BIT  = 0;
   localparam int          FLAG_DESCRIPTOR_BIT = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int RSP_DATA_W = 128;

   typedef enum logic [3:0] {
      PH_SIG,
      PH_VER,
      PH_FLAG,
      PH_MISC,
      PH_CRC,
      PH_CSIZE,
      PH_USIZE,
      PH_NLEN,
      PH_XLEN,
      PH_NAME,
      PH_EXTRA,
      PH_ENC,
      PH_INIT,
      PH_SKIP,
      PH_HALT
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NAME,
      KIND_ENC,
      KIND_INIT,
      KIND_SUMMARY,
      KIND_STOP
   } kind_type;

   typedef enum logic [2:0] {
      STOP_SIGNATURE,
      STOP_VERSION,
      STOP_DESCRIPTOR,
      STOP_ZIP64,
      STOP_ENC_SHORT,
      STOP_DATA_SHORT
   } stop_type;

   // one byte's worth of results: an optional byte result, then an optional tail
   typedef struct packed {
      logic        has_byte;
      kind_type    byte_kind;
      logic [7:0]  byte_value;
      logic [15:0] byte_index;
      logic        has_tail;
      logic        tail_stop;
      stop_type    reason;
      logic [31:0] crc;
      logic [31:0] packed_size;
      logic [31:0] original_size;
      logic        encrypted;
   } work_type;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [3:0]  pad;
      logic [2:0]  stop_reason;
      logic        is_encrypted;
      logic [31:0] original_size;
      logic [31:0] packed_size;
      logic [31:0] crc_value;
      logic [15:0] byte_index;
      logic [7:0]  byte_value;
   } rsp_data_type;

   function automatic logic [2:0] field_len(phase_type ph);
      logic [2:0] len;
      unique case (ph)
         PH_SIG, PH_CRC, PH_CSIZE, PH_USIZE: len = 3'd4;
         PH_MISC:                            len = 3'd6;
         default:                            len = 3'd2;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/core/zip_local_header_parser.sv =====
// channel   dir  payload
// req_      in   tdata[7:0] data_byte
// rsp_      out  tdata: byte_value, byte_index, crc_value, packed_size,
//                original_size, is_encrypted, stop_reason, zero pad;
//                tuser: kind; tlast: last_of_run
//
// One byte accepted per cycle while req_tready is high; it gives zero, one or two results.
// A byte's results pass through a queue entry and then the output register; a second
// result follows the first; results leave one per cycle while rsp_tready is high.
// A four-entry queue between parser and output stage absorbs two-result bytes and
// output stalls; req_tready drops only when it is full.
// Synchronous reset returns the parser to the signature field and empties the queue.
module zip_local_header_parser
   import zlh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // data_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // byte_value[7:0], byte_index[23:8], crc_value[55:24], packed_size[87:56],
   // original_size[119:88], is_encrypted[120], stop_reason[123:121], zero[127:124]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser,  // kind
   output logic                  rsp_tlast
);

   logic     push;
   work_type push_item;
   logic     pop;
   work_type head;
   logic     q_valid;
   logic     q_full;

   zlh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   zlh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .q_valid   (q_valid),
      .q_full    (q_full)
   );

   zlh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_valid    (q_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/zlh_front.sv =====
module zlh_front
   import zlh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       q_full,
   output logic       push,
   output work_type   push_item
);

   phase_type   phase_ff, phase_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [31:0] asm_ff, asm_in;
   logic        enc_ff, enc_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] psize_ff, psize_in;
   logic [31:0] osize_ff, osize_in;
   logic [15:0] nlen_ff, nlen_in;
   logic [15:0] xlen_ff, xlen_in;
   logic [31:0] skip_ff, skip_in;
   logic        nterm_ff, nterm_in;

   logic        accept;
   logic [7:0]  byte_in;
   logic [15:0] cnt_inc;
   logic [31:0] word;
   logic        fld_done;
   logic        name_end, extra_end, enc_end, init_end;
   logic        enc_short, data_short, enc_data_short;
   logic [31:0] psize_less_enc, skip_init, skip_dec;
   logic        hdr_end;
   phase_type   fin_phase;
   work_type    item;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign byte_in    = req_tdata;
   assign cnt_inc    = cnt_ff + 16'd1;

   assign word = (cnt_ff < 16'd4) ? (asm_ff | (32'(byte_in) << {cnt_ff[1:0], 3'b000}))
                                  : asm_ff;
   assign fld_done  = (cnt_inc == 16'(field_len(phase_ff)));
   assign name_end  = (cnt_inc == nlen_ff);
   assign extra_end = (cnt_inc == xlen_ff);
   assign enc_end   = (phase_ff == PH_ENC)  && (cnt_inc == 16'(ENC_HEADER_BYTES));
   assign init_end  = (phase_ff == PH_INIT) && (cnt_inc == 16'(INITIAL_BYTES));

   assign psize_less_enc = psize_ff - 32'(ENC_HEADER_BYTES);
   assign skip_init      = psize_ff - 32'(INITIAL_BYTES);
   assign skip_dec       = skip_ff - 32'd1;
   assign enc_short      = (psize_ff < 32'(ENC_HEADER_BYTES));
   assign data_short     = (psize_ff < 32'(INITIAL_BYTES));
   assign enc_data_short = (psize_less_enc < 32'(INITIAL_BYTES));

   // header, name and extra field all consumed on this byte
   assign hdr_end = ((phase_ff == PH_XLEN) && fld_done && (nlen_ff == 16'd0) &&
                     (word[15:0] == 16'd0)) ||
                    ((phase_ff == PH_NAME) && name_end && (xlen_ff == 16'd0)) ||
                    ((phase_ff == PH_EXTRA) && extra_end);

   assign fin_phase = enc_ff ? (enc_short ? PH_HALT : PH_ENC)
                             : (data_short ? PH_HALT : PH_INIT);

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_SIG:   if (fld_done) phase_in = (word != SIG_VALUE) ? PH_HALT : PH_VER;
            PH_VER:   if (fld_done) phase_in = (word != VERSION_VALUE) ? PH_HALT : PH_FLAG;
            PH_FLAG:  if (fld_done) phase_in = word[FLAG_DESCRIPTOR_BIT] ? PH_HALT : PH_MISC;
            PH_MISC:  if (fld_done) phase_in = PH_CRC;
            PH_CRC:   if (fld_done) phase_in = PH_CSIZE;
            PH_CSIZE: if (fld_done) phase_in = (word == ZIP64_SIZE) ? PH_HALT : PH_USIZE;
            PH_USIZE: if (fld_done) phase_in = PH_NLEN;
            PH_NLEN:  if (fld_done) phase_in = PH_XLEN;
            PH_XLEN: begin
               if (fld_done) begin
                  if (nlen_ff != 16'd0)          phase_in = PH_NAME;
                  else if (word[15:0] != 16'd0)  phase_in = PH_EXTRA;
                  else                           phase_in = fin_phase;
               end
            end
            PH_NAME: begin
               if (name_end) phase_in = (xlen_ff != 16'd0) ? PH_EXTRA : fin_phase;
            end
            PH_EXTRA: if (extra_end) phase_in = fin_phase;
            PH_ENC:   if (enc_end) phase_in = enc_data_short ? PH_HALT : PH_INIT;
            PH_INIT:  if (init_end) phase_in = (skip_init == 32'd0) ? PH_SIG : PH_SKIP;
            PH_SKIP:  if (skip_dec == 32'd0) phase_in = PH_SIG;
            PH_HALT:  phase_in = PH_HALT;
            default:  phase_in = PH_HALT;
         endcase
      end
   end

   always_comb begin
      cnt_in   = cnt_ff;
      asm_in   = asm_ff;
      enc_in   = enc_ff;
      crc_in   = crc_ff;
      psize_in = psize_ff;
      osize_in = osize_ff;
      nlen_in  = nlen_ff;
      xlen_in  = xlen_ff;
      skip_in  = skip_ff;
      nterm_in = nterm_ff;
      if (accept) begin
         if (phase_ff <= PH_XLEN) begin
            if (fld_done) begin
               cnt_in = 16'd0;
               asm_in = 32'd0;
               case (phase_ff)
                  PH_FLAG:  enc_in = word[FLAG_ENCRYPTED_BIT];
                  PH_CRC:   crc_in = word;
                  PH_CSIZE: psize_in = word;
                  PH_USIZE: osize_in = word;
                  PH_NLEN: begin
                     nlen_in  = word[15:0];
                     nterm_in = 1'b0;
                  end
                  PH_XLEN:  xlen_in = word[15:0];
                  default:  ;
               endcase
            end else begin
               cnt_in = cnt_inc;
               asm_in = word;
            end
         end else begin
            case (phase_ff)
               PH_NAME: begin
                  if (!nterm_ff && (byte_in == 8'd0)) nterm_in = 1'b1;
                  cnt_in = name_end ? 16'd0 : cnt_inc;
               end
               PH_EXTRA: cnt_in = extra_end ? 16'd0 : cnt_inc;
               PH_ENC: begin
                  cnt_in = enc_end ? 16'd0 : cnt_inc;
                  if (enc_end) psize_in = psize_less_enc;
               end
               PH_INIT: begin
                  cnt_in = init_end ? 16'd0 : cnt_inc;
                  if (init_end) skip_in = skip_init;
               end
               PH_SKIP: skip_in = skip_dec;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      item               = '0;
      item.crc           = crc_ff;
      item.packed_size   = psize_ff;
      item.original_size = osize_ff;
      item.encrypted     = enc_ff;
      item.byte_value    = byte_in;
      item.byte_index    = cnt_ff;
      item.byte_kind     = KIND_NAME;
      item.reason        = STOP_SIGNATURE;

      case (phase_ff)
         PH_NAME: item.has_byte = !nterm_ff && (byte_in != 8'd0);
         PH_ENC: begin
            item.has_byte  = 1'b1;
            item.byte_kind = KIND_ENC;
         end
         PH_INIT: begin
            item.has_byte  = 1'b1;
            item.byte_kind = KIND_INIT;
         end
         default: ;
      endcase

      if ((phase_ff == PH_SIG) && fld_done && (word != SIG_VALUE)) begin
         item.tail_stop = 1'b1;
         item.reason    = STOP_SIGNATURE;
      end else if ((phase_ff == PH_VER) && fld_done && (word != VERSION_VALUE)) begin
         item.tail_stop = 1'b1;
         item.reason    = STOP_VERSION;
      end else if ((phase_ff == PH_FLAG) && fld_done && word[FLAG_DESCRIPTOR_BIT]) begin
         item.tail_stop = 1'b1;
         item.reason    = STOP_DESCRIPTOR;
      end else if ((phase_ff == PH_CSIZE) && fld_done && (word == ZIP64_SIZE)) begin
         item.tail_stop = 1'b1;
         item.reason    = STOP_ZIP64;
      end else if (hdr_end && enc_ff && enc_short) begin
         item.tail_stop = 1'b1;
         item.reason    = STOP_ENC_SHORT;
      end else if ((hdr_end && !enc_ff && data_short) || (enc_end && enc_data_short)) begin
         item.tail_stop = 1'b1;
         item.reason    = STOP_DATA_SHORT;
      end

      item.has_tail = item.tail_stop ||
                      (init_end && (skip_init == 32'd0)) ||
                      ((phase_ff == PH_SKIP) && (skip_dec == 32'd0));

      push      = accept && (item.has_byte || item.has_tail);
      push_item = item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIG;
         cnt_ff   <= '0;
         asm_ff   <= '0;
         enc_ff   <= 1'b0;
         crc_ff   <= '0;
         psize_ff <= '0;
         osize_ff <= '0;
         nlen_ff  <= '0;
         xlen_ff  <= '0;
         skip_ff  <= '0;
         nterm_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         asm_ff   <= asm_in;
         enc_ff   <= enc_in;
         crc_ff   <= crc_in;
         psize_ff <= psize_in;
         osize_ff <= osize_in;
         nlen_ff  <= nlen_in;
         xlen_ff  <= xlen_in;
         skip_ff  <= skip_in;
         nterm_ff <= nterm_in;
      end
   end

endmodule

// ===== rtl/core/zlh_queue.sv =====
module zlh_queue
   import zlh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_item,
   input  logic     pop,
   output work_type head,
   output logic     q_valid,
   output logic     q_full
);

   work_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign head    = mem_ff[rd_ff];
   assign q_valid = (cnt_ff != '0);
   assign q_full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/zlh_back.sv =====
module zlh_back
   import zlh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  work_type              head,
   input  logic                  q_valid,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   logic         valid_ff, valid_in;
   kind_type     kind_ff, kind_in;
   rsp_data_type data_ff, data_in;
   logic         last_ff, last_in;
   logic         second_ff, second_in;

   logic load;
   logic emit_byte;

   assign load      = q_valid && (!valid_ff || rsp_tready);
   assign emit_byte = head.has_byte && !second_ff;
   assign pop       = load && !(emit_byte && head.has_tail);

   always_comb begin
      valid_in  = valid_ff;
      kind_in   = kind_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      second_in = second_ff;
      if (load) begin
         valid_in  = 1'b1;
         second_in = emit_byte && head.has_tail;
         data_in   = '0;
         if (emit_byte) begin
            kind_in            = head.byte_kind;
            data_in.byte_value = head.byte_value;
            data_in.byte_index = head.byte_index;
            last_in            = !head.has_tail;
         end else if (head.tail_stop) begin
            kind_in             = KIND_STOP;
            data_in.stop_reason = head.reason;
            last_in             = 1'b1;
         end else begin
            kind_in               = KIND_SUMMARY;
            data_in.crc_value     = head.crc;
            data_in.packed_size   = head.packed_size;
            data_in.original_size = head.original_size;
            data_in.is_encrypted  = head.encrypted;
            last_in               = 1'b1;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule
